FILE: hdl/gct_pkg.sv
// Shared types and constants for the greedy centroid tracker.
// No dependencies; used by gct_ctrl, gct_dp and greedy_centroid_tracker.
package gct_pkg;

   localparam int MaxTracksDefault = 16;
   localparam int MaxDetsDefault   = 16;

   localparam int CoordW  = 16;
   localparam int IdW     = 16;
   localparam int AgeW    = 16;
   localparam int UnseenW = 8;
   localparam int DropW   = 8;
   localparam int CsrAddrW = 1;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 2 * CoordW;
   localparam int RspDataW = IdW + 2 * CoordW + AgeW + UnseenW + DropW;

   localparam logic [CsrAddrW-1:0] CSR_MAX_UNSEEN = 1'd0;
   localparam logic [CsrAddrW-1:0] CSR_MATCH_DIST = 1'd1;

   localparam logic [UnseenW-1:0] MAX_UNSEEN_RST = 8'd30;
   localparam logic [CoordW-1:0]  MATCH_DIST_RST = 16'd800;

   typedef struct packed {
      logic store;        // buffer the accepted item
      logic frame_start;  // latch squared limit, clear used flags
      logic clr;          // zero the slot and detection counters
      logic scan;         // issue one track/detection pair
      logic apply;        // commit the best pair of the round
      logic age;          // age one slot
      logic create;       // place one detection
      logic report;       // emit one slot
      logic finish;       // clear buffer and drop count
   } cmd_type;

   typedef struct packed {
      logic t_last;
      logic d_last;
      logic det_empty;
      logic pipe_busy;
      logic found;
      logic rep_done;
   } status_type;

endpackage

FILE: hdl/gct_ctrl.sv
// Frame sequencer of the greedy centroid tracker.
// Depends on gct_pkg; drives gct_dp through cmd_type and reads status_type.
module gct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_end,
   output logic                req_tready,
   input  gct_pkg::status_type st,
   output gct_pkg::cmd_type    cmd
);
   import gct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_APPLY, ST_AGE, ST_CREATE, ST_REPORT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.clr = 1'b1;
            if (req_tvalid) begin
               cmd.store = 1'b1;
               if (req_end) begin
                  cmd.frame_start = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (st.det_empty) begin
               cmd.clr  = 1'b1;
               state_in = ST_AGE;
            end else begin
               cmd.scan = 1'b1;
               if (st.t_last && st.d_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.clr = 1'b1;
            if (!st.pipe_busy) state_in = st.found ? ST_APPLY : ST_AGE;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            cmd.clr   = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_AGE: begin
            cmd.age = 1'b1;
            if (st.t_last) begin
               cmd.clr  = 1'b1;
               state_in = st.det_empty ? ST_REPORT : ST_CREATE;
            end
         end
         ST_CREATE: begin
            cmd.create = 1'b1;
            if (st.d_last) begin
               cmd.clr  = 1'b1;
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            if (st.rep_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/gct_dp.sv
// Datapath of the greedy centroid tracker: track table, detection buffer,
// distance pipeline, config registers and result register. Depends on gct_pkg.
module gct_dp #(
   parameter int MAX_TRACKS = gct_pkg::MaxTracksDefault,
   parameter int MAX_DETS   = gct_pkg::MaxDetsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gct_pkg::cmd_type                     cmd,
   output gct_pkg::status_type                  st,
   input  logic [gct_pkg::ReqDataW-1:0]         req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 csr_wen,
   input  logic [gct_pkg::CsrAddrW-1:0]         csr_addr,
   input  logic [gct_pkg::CsrDataW-1:0]         csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gct_pkg::RspDataW-1:0]         rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import gct_pkg::*;

   localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int DW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
   localparam int CW = $clog2(MAX_DETS + 1);

   // configuration
   logic [UnseenW-1:0] max_unseen_ff;
   logic [CoordW-1:0]  match_dist_ff;
   logic [2*CoordW-1:0] limit_ff;

   // track table
   logic [MAX_TRACKS-1:0] live_ff, tused_ff;
   logic [IdW-1:0]     id_ff     [MAX_TRACKS];
   logic [CoordW-1:0]  sx_ff     [MAX_TRACKS];
   logic [CoordW-1:0]  sy_ff     [MAX_TRACKS];
   logic [AgeW-1:0]    age_ff    [MAX_TRACKS];
   logic [UnseenW-1:0] unseen_ff [MAX_TRACKS];

   // detection buffer
   logic [MAX_DETS-1:0] dused_ff;
   logic [CoordW-1:0]   dx_buf_ff [MAX_DETS];
   logic [CoordW-1:0]   dy_buf_ff [MAX_DETS];
   logic [CW-1:0]       det_cnt_ff;
   logic [DropW-1:0]    drop_ff;
   logic [IdW-1:0]      next_id_ff;

   logic [TW-1:0] t_ff;
   logic [DW-1:0] d_ff;

   // distance pipeline
   logic              v1_ff, v2_ff;
   logic [TW-1:0]     t1_ff, t2_ff;
   logic [DW-1:0]     d1_ff, d2_ff;
   logic [CoordW-1:0] adx_ff, ady_ff;
   logic [2*CoordW-1:0] sqx_ff, sqy_ff;
   logic [2*CoordW:0] pair_dist;
   logic              better;
   logic              found_ff;
   logic [2*CoordW:0] best_ff;
   logic [TW-1:0]     bt_ff;
   logic [DW-1:0]     bd_ff;

   // result register
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;
   logic                rsp_user_ff, rsp_last_ff;

   logic [CW-1:0] cnt_m1;
   logic [DW-1:0] d_lastv;
   logic          t_last, d_last;
   logic          issue;
   logic          free_found;
   logic [TW-1:0] free_idx;
   logic          more_live, any_live, out_free, emit, rep_done;
   logic [CoordW-1:0] cur_dx, cur_dy;
   logic [UnseenW-1:0] unseen_next;

   assign cnt_m1  = det_cnt_ff - 1'b1;
   assign d_lastv = cnt_m1[DW-1:0];
   assign t_last  = (t_ff == TW'(MAX_TRACKS - 1));
   assign d_last  = (d_ff == d_lastv);
   assign cur_dx  = dx_buf_ff[d_ff];
   assign cur_dy  = dy_buf_ff[d_ff];
   assign issue   = cmd.scan && live_ff[t_ff] && !tused_ff[t_ff] && !dused_ff[d_ff];

   assign pair_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign better    = v2_ff && (pair_dist <= {1'b0, limit_ff}) &&
                      (!found_ff || pair_dist < best_ff);

   assign unseen_next = (unseen_ff[t_ff] != '1) ? unseen_ff[t_ff] + 1'b1 : unseen_ff[t_ff];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_idx   = TW'(i);
         end
      end
   end

   always_comb begin
      more_live = 1'b0;
      for (int i = 0; i < MAX_TRACKS; i++) begin
         if (live_ff[i] && (i > int'(t_ff))) more_live = 1'b1;
      end
   end

   assign any_live = |live_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = cmd.report && out_free && (!any_live || live_ff[t_ff]);
   assign rep_done = emit && (!any_live || !more_live);

   assign st.t_last    = t_last;
   assign st.d_last    = d_last;
   assign st.det_empty = (det_cnt_ff == '0);
   assign st.pipe_busy = v1_ff || v2_ff;
   assign st.found     = found_ff;
   assign st.rep_done  = rep_done;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_unseen_ff <= MAX_UNSEEN_RST;
         match_dist_ff <= MATCH_DIST_RST;
         live_ff       <= '0;
         det_cnt_ff    <= '0;
         drop_ff       <= '0;
         next_id_ff    <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         t_ff          <= '0;
         d_ff          <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_addr)
               CSR_MAX_UNSEEN: max_unseen_ff <= csr_wdata[UnseenW-1:0];
               CSR_MATCH_DIST: match_dist_ff <= csr_wdata;
               default: ;
            endcase
         end

         // input buffering; drop when the buffer is full
         if (cmd.store && !req_tuser) begin
            if (det_cnt_ff != CW'(MAX_DETS)) begin
               det_cnt_ff <= det_cnt_ff + 1'b1;
            end else if (drop_ff != '1) begin
               drop_ff <= drop_ff + 1'b1;
            end
         end

         // index counters
         if (cmd.clr) begin
            t_ff <= '0;
            d_ff <= '0;
         end else if (cmd.scan) begin
            if (d_last) begin
               d_ff <= '0;
               t_ff <= t_ff + 1'b1;
            end else begin
               d_ff <= d_ff + 1'b1;
            end
         end else if (cmd.age) begin
            t_ff <= t_ff + 1'b1;
         end else if (cmd.create) begin
            d_ff <= d_ff + 1'b1;
         end else if (cmd.report && !rep_done && (emit || !live_ff[t_ff])) begin
            t_ff <= t_ff + 1'b1;
         end

         v1_ff <= issue;
         v2_ff <= v1_ff;

         if (cmd.frame_start || cmd.apply) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end

         // drop tracks unmatched for too long
         if (cmd.age && live_ff[t_ff] && !tused_ff[t_ff] && (unseen_next > max_unseen_ff)) begin
            live_ff[t_ff] <= 1'b0;
         end

         // open tracks for unmatched detections in arrival order
         if (cmd.create && !dused_ff[d_ff]) begin
            if (free_found) begin
               live_ff[free_idx] <= 1'b1;
               next_id_ff        <= next_id_ff + 1'b1;
            end else if (drop_ff != '1) begin
               drop_ff <= drop_ff + 1'b1;
            end
         end

         if (cmd.finish) begin
            det_cnt_ff <= '0;
            drop_ff    <= '0;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.store && !req_tuser && det_cnt_ff != CW'(MAX_DETS)) begin
         dx_buf_ff[det_cnt_ff[DW-1:0]] <= req_tdata[CoordW-1:0];
         dy_buf_ff[det_cnt_ff[DW-1:0]] <= req_tdata[2*CoordW-1:CoordW];
      end

      if (cmd.frame_start) begin
         limit_ff <= (2*CoordW)'(match_dist_ff) * (2*CoordW)'(match_dist_ff);
         tused_ff <= '0;
         dused_ff <= '0;
      end

      // stage one: absolute differences
      t1_ff  <= t_ff;
      d1_ff  <= d_ff;
      adx_ff <= (sx_ff[t_ff] > cur_dx) ? sx_ff[t_ff] - cur_dx : cur_dx - sx_ff[t_ff];
      ady_ff <= (sy_ff[t_ff] > cur_dy) ? sy_ff[t_ff] - cur_dy : cur_dy - sy_ff[t_ff];
      // stage two: squares
      t2_ff  <= t1_ff;
      d2_ff  <= d1_ff;
      sqx_ff <= (2*CoordW)'(adx_ff) * (2*CoordW)'(adx_ff);
      sqy_ff <= (2*CoordW)'(ady_ff) * (2*CoordW)'(ady_ff);
      // keep the first strictly closer pair in scan order
      if (better) begin
         best_ff <= pair_dist;
         bt_ff   <= t2_ff;
         bd_ff   <= d2_ff;
      end

      if (cmd.apply) begin
         tused_ff[bt_ff]  <= 1'b1;
         dused_ff[bd_ff]  <= 1'b1;
         sx_ff[bt_ff]     <= dx_buf_ff[bd_ff];
         sy_ff[bt_ff]     <= dy_buf_ff[bd_ff];
         unseen_ff[bt_ff] <= '0;
         if (age_ff[bt_ff] != '1) age_ff[bt_ff] <= age_ff[bt_ff] + 1'b1;
      end

      if (cmd.age && live_ff[t_ff] && !tused_ff[t_ff]) begin
         unseen_ff[t_ff] <= unseen_next;
      end

      if (cmd.create && !dused_ff[d_ff] && free_found) begin
         id_ff[free_idx]     <= next_id_ff;
         sx_ff[free_idx]     <= cur_dx;
         sy_ff[free_idx]     <= cur_dy;
         age_ff[free_idx]    <= '0;
         unseen_ff[free_idx] <= '0;
      end

      if (emit) begin
         rsp_last_ff <= rep_done;
         if (any_live) begin
            rsp_user_ff <= 1'b0;
            rsp_data_ff <= {drop_ff, unseen_ff[t_ff], age_ff[t_ff], sy_ff[t_ff],
                            sx_ff[t_ff], id_ff[t_ff]};
         end else begin
            rsp_user_ff <= 1'b1;
            rsp_data_ff <= {drop_ff, {(RspDataW-DropW){1'b0}}};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/greedy_centroid_tracker.sv
// Greedy centroid tracker top level: joins the frame sequencer and datapath.
// Depends on gct_pkg, gct_ctrl and gct_dp.
//
// The tracker buffers one frame's detections (up to MAX_DETS, extras are
// dropped and counted) and does all work when the frame's last transfer
// arrives (tlast, or tuser marking an empty frame). While a frame is being
// processed req_tready is low. Matching runs in rounds: each round walks every
// slot against every buffered detection, one pair per clock, and sends the
// free live pairs through a squared-distance pipeline (difference, square,
// compare); the round ends by draining the pipeline and applying the best
// match if any, and a frame that holds detections and has m matches takes
// (m+1) rounds. Then ageing walks every slot, track opening walks every
// buffered detection, and the report walks the slots one per clock,
// emitting one transfer per live track in slot order (a single no_tracks
// transfer when none is live), with tlast on the final one; a stalled result
// holds the walk. Configuration writes are taken at any time but are only
// meant while the block is idle.
module greedy_centroid_tracker #(
   parameter int MAX_TRACKS = gct_pkg::MaxTracksDefault,
   parameter int MAX_DETS   = gct_pkg::MaxDetsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gct_pkg::ReqDataW-1:0]  req_tdata,   // det_x, det_y
   input  logic                          req_tlast,   // frame_end
   input  logic                          req_tuser,   // empty_frame
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // track_id, track_x, track_y, track_age, frames_unseen, dropped_detections
   output logic [gct_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tlast,   // last_track
   output logic                          rsp_tuser,   // no_tracks
   input  logic                          csr_wen,
   input  logic [gct_pkg::CsrAddrW-1:0]  csr_addr,
   input  logic [gct_pkg::CsrDataW-1:0]  csr_wdata
);
   import gct_pkg::*;

   cmd_type    cmd;
   status_type st;

   // an empty-frame marker ends the frame whatever tlast says
   gct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_end    (req_tlast | req_tuser),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   gct_dp #(
      .MAX_TRACKS (MAX_TRACKS),
      .MAX_DETS   (MAX_DETS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
